### rtl/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
// Used by the top level table_linear_interpolator; no dependencies.
package tli_pkg;

  // Payload widths.
  localparam int unsigned ValW    = 32;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned InDataW = 104;

  // Fixed point: weights carry 16 fraction bits, 1.0 needs a 17th bit.
  localparam int unsigned FracW = 16;
  localparam int unsigned WgtW  = FracW + 1;
  localparam logic [WgtW-1:0] OneQ16 = 17'h10000;

  // Serial step counts of the divider and the multiplier.
  localparam logic [4:0] DivSteps = 5'd16;
  localparam logic [4:0] MulSteps = 5'd17;

  // Configuration register map (word index) and reset value.
  localparam logic RegEntriesInUse = 1'b0;
  localparam logic [CfgW-1:0] EntriesReset = 9'd2;

  // Meaning of the input selector.
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_e;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_LOW   = 11'b000_0000_0010,
    S_HIGH  = 11'b000_0000_0100,
    S_PROBE = 11'b000_0000_1000,
    S_CMP   = 11'b000_0001_0000,
    S_RDHI  = 11'b000_0010_0000,
    S_RDLO  = 11'b000_0100_0000,
    S_DIV   = 11'b000_1000_0000,
    S_MUL   = 11'b001_0000_0000,
    S_SUM   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

endpackage

### rtl/tli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module tli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/table_linear_interpolator.sv
// Table linear interpolator: a table of ascending abscissas and ordinates (signed Q16.16)
// with a binary search, a bit-serial divider and a bit-serial multiplier.
// Depends on tli_pkg and tli_ram.
//
// Input stream: s_axis_tuser selects the transaction kind. A load (tuser 0) writes one
// abscissa/ordinate pair at entry_index and produces no result; loads are taken one per
// cycle while no query is in progress. A query (tuser 1) returns one result on the output
// stream: the value and a clamp code in m_axis_tuser (0 inside, 1 clamped low,
// 2 clamped high). A query that clamps ends after its compares against the end entries.
// Otherwise it searches with at most p = floor(log2(n)) + 1 probes over the n entries in
// use; each probe is one table read plus one compare, the weight comes from a restoring
// divider at one bit per cycle and the blend from a shift-add multiplier at one weight
// bit per cycle. When the weight is 0 or 1 the divider is skipped. One query is worked on
// at a time; the input is not ready while a query is in progress and is ready again on
// the cycle after the result is registered.
// A finished result sits in an output register, so the next transaction can be taken while
// the receiver stalls; a query that finishes while that register is still full waits.
// Reset clears the control state and sets entries_in_use to 2; the table contents stay
// undefined until loaded. entries_in_use is at APB byte address 0.
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: entry_index[7:0], abscissa_value[39:8], ordinate_value[71:40],
  // query_point[103:72].
  input  logic [tli_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: func[0].
  input  logic                          s_axis_tuser,
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: interpolated_value[31:0].
  output logic [tli_pkg::ValW-1:0]      m_axis_tdata,
  // tuser: clamp_code[1:0].
  output logic [1:0]                    m_axis_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tli_pkg::ApbAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import tli_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AccW = ValW + 1 + WgtW;

  // Input fields.
  logic [IdxW-1:0]        entry_index;
  logic [ValW-1:0]        abscissa_value;
  logic [ValW-1:0]        ordinate_value;
  logic signed [ValW-1:0] query_point;

  assign entry_index    = s_axis_tdata[7:0];
  assign abscissa_value = s_axis_tdata[39:8];
  assign ordinate_value = s_axis_tdata[71:40];
  assign query_point    = s_axis_tdata[103:72];

  // Configuration register.
  logic [CfgW-1:0] entries_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegEntriesInUse);
  assign prdata = (paddr[2] == RegEntriesInUse) ? {23'b0, entries_q} : 32'b0;

  // Active entry count, saturated into 2..TABLE_DEPTH.
  logic [31:0]   cfg_ext;
  logic [31:0]   n_ext;
  logic [NW-1:0] n_c;
  logic [AW-1:0] last_c;

  assign cfg_ext = {23'b0, entries_q};

  always_comb begin
    if (cfg_ext < 32'd2) begin
      n_ext = 32'd2;
    end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
      n_ext = 32'(TABLE_DEPTH);
    end else begin
      n_ext = cfg_ext;
    end
  end

  assign n_c = n_ext[NW-1:0];
  assign last_c = n_ext[AW-1:0] - AW'(1);

  // Sequencer state.
  state_e state_q, state_d;

  // Handshakes.
  logic in_acc;
  logic is_query;
  logic wr_en;
  logic [31:0] widx_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_query = (s_axis_tuser == FuncQuery);
  assign widx_ext = {24'b0, entry_index};
  assign wr_en    = in_acc && (s_axis_tuser == FuncLoad) && (widx_ext < 32'(TABLE_DEPTH));

  // Table memories.
  logic [AW-1:0]  rd_addr;
  logic [ValW-1:0] x_rd;
  logic [ValW-1:0] y_rd;

  tli_ram #(.Width(ValW), .Depth(TABLE_DEPTH)) u_abscissa_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (widx_ext[AW-1:0]),
    .wdata_i (abscissa_value),
    .raddr_i (rd_addr),
    .rdata_o (x_rd)
  );

  tli_ram #(.Width(ValW), .Depth(TABLE_DEPTH)) u_ordinate_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (widx_ext[AW-1:0]),
    .wdata_i (ordinate_value),
    .raddr_i (rd_addr),
    .rdata_o (y_rd)
  );

  // Sequencer registers.
  logic                   out_valid_q, out_valid_d;
  logic [ValW-1:0]        out_data_q, out_data_d;
  clamp_e                 out_code_q, out_code_d;
  logic signed [ValW-1:0] q_q, q_d;
  logic [NW-1:0]          first_q, first_d;
  logic [NW-1:0]          count_q, count_d;
  logic [AW-1:0]          probe_q, probe_d;
  logic [AW-1:0]          hi_q, hi_d;
  logic signed [ValW-1:0] x_hi_q, x_hi_d;
  logic [ValW-1:0]        y_hi_q, y_hi_d;
  logic [ValW:0]          diff_q, diff_d;
  logic [ValW:0]          rem_q, rem_d;
  logic [ValW:0]          den_q, den_d;
  logic [WgtW-1:0]        t_q, t_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [4:0]             cnt_q, cnt_d;
  logic [ValW-1:0]        res_q, res_d;
  clamp_e                 code_q, code_d;

  // Datapath helpers.
  logic signed [ValW-1:0] x_rd_s;
  logic [NW-1:0]          step_c;
  logic [NW-1:0]          probe_full;
  logic [AW-1:0]          hi_c;
  logic signed [ValW:0]   num_c;
  logic signed [ValW:0]   den_c;
  logic [ValW+1:0]        rem2_c;
  logic signed [AccW-1:0] addend_c;
  logic signed [AccW-1:0] sum_c;

  assign x_rd_s     = $signed(x_rd);
  assign step_c     = count_q >> 1;
  assign probe_full = first_q + step_c;
  assign num_c      = {x_hi_q[ValW-1], x_hi_q} - {q_q[ValW-1], q_q};
  assign den_c      = {x_hi_q[ValW-1], x_hi_q} - {x_rd_s[ValW-1], x_rd_s};
  assign rem2_c     = {rem_q, 1'b0};
  assign addend_c   = t_q[WgtW-1] ? {{(AccW-ValW-1){diff_q[ValW]}}, diff_q} : '0;
  assign sum_c      = $signed({{(AccW-ValW-FracW){y_hi_q[ValW-1]}}, y_hi_q, {FracW{1'b0}}})
                      + acc_q;

  // Upper neighbor held within 1..n-1.
  always_comb begin
    if (first_q < NW'(1)) begin
      hi_c = AW'(1);
    end else if (first_q > NW'(last_c)) begin
      hi_c = last_c;
    end else begin
      hi_c = first_q[AW-1:0];
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_addr = '0;
      S_LOW:   rd_addr = last_c;
      S_PROBE: rd_addr = (count_q == '0) ? hi_c : probe_full[AW-1:0];
      S_RDHI:  rd_addr = hi_q - AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_code_d  = out_code_q;
    q_d         = q_q;
    first_d     = first_q;
    count_d     = count_q;
    probe_d     = probe_q;
    hi_d        = hi_q;
    x_hi_d      = x_hi_q;
    y_hi_d      = y_hi_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    den_d       = den_q;
    t_d         = t_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    code_d      = code_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && is_query) begin
          q_d     = query_point;
          state_d = S_LOW;
        end
      end
      S_LOW: begin
        if (q_q <= x_rd_s) begin
          res_d   = y_rd;
          code_d  = CLAMP_LOW;
          state_d = S_DONE;
        end else begin
          state_d = S_HIGH;
        end
      end
      S_HIGH: begin
        if (q_q >= x_rd_s) begin
          res_d   = y_rd;
          code_d  = CLAMP_HIGH;
          state_d = S_DONE;
        end else begin
          first_d = '0;
          count_d = n_c;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (count_q == '0) begin
          hi_d    = hi_c;
          state_d = S_RDHI;
        end else begin
          probe_d = probe_full[AW-1:0];
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!(q_q < x_rd_s)) begin
          first_d = NW'(probe_q) + NW'(1);
          count_d = count_q - step_c - NW'(1);
        end else begin
          count_d = step_c;
        end
        state_d = S_PROBE;
      end
      S_RDHI: begin
        x_hi_d  = x_rd_s;
        y_hi_d  = y_rd;
        state_d = S_RDLO;
      end
      S_RDLO: begin
        diff_d = {y_rd[ValW-1], y_rd} - {y_hi_q[ValW-1], y_hi_q};
        rem_d  = num_c;
        den_d  = den_c;
        cnt_d  = MulSteps;
        acc_d  = '0;
        if (den_c <= 0 || num_c >= den_c) begin
          t_d     = OneQ16;
          state_d = S_MUL;
        end else if (num_c <= 0) begin
          t_d     = '0;
          state_d = S_MUL;
        end else begin
          // 0 < num < den, so the quotient fits in 16 fraction bits.
          t_d     = '0;
          cnt_d   = DivSteps;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem2_c >= {1'b0, den_q}) begin
          rem_d = (ValW+1)'(rem2_c - {1'b0, den_q});
          t_d   = {t_q[WgtW-2:0], 1'b1};
        end else begin
          rem_d = rem2_c[ValW:0];
          t_d   = {t_q[WgtW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          cnt_d   = MulSteps;
          acc_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // Most significant weight bit first: acc = 2*acc + bit*diff.
        acc_d = (acc_q <<< 1) + addend_c;
        t_d   = {t_q[WgtW-2:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        // Arithmetic shift right by 16 is the floor of the blend.
        res_d   = sum_c[ValW+FracW-1:FracW];
        code_d  = CLAMP_NONE;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          out_code_d  = code_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      entries_q   <= EntriesReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        entries_q <= pwdata[CfgW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_code_q <= out_code_d;
    q_q        <= q_d;
    first_q    <= first_d;
    count_q    <= count_d;
    probe_q    <= probe_d;
    hi_q       <= hi_d;
    x_hi_q     <= x_hi_d;
    y_hi_q     <= y_hi_d;
    diff_q     <= diff_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    t_q        <= t_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    code_q     <= code_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_code_q;

  // A finished query must not overwrite a result the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("finished query left while output register was full");

  // The divider remainder stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < den_q))
    else $error("divider remainder reached the divisor");

  // Every search probe addresses an entry in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (probe_q <= last_c))
    else $error("search probe beyond the last entry in use");

  // Weight never exceeds 1.0 when the blend starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(state_q == S_MUL)) |-> (t_q <= OneQ16))
    else $error("interpolation weight above one");

endmodule
